// ===== design/sdhs_pkg.sv =====
// ----------------------------------------------------------------------------
// sdhs_pkg
// Shared types and constants for the switch debounce / hold start block.
// ----------------------------------------------------------------------------
package sdhs_pkg;

    // Fixed field widths
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET    = 16'd100;
    localparam logic [CFG_W-1:0] START_DELAY_RESET = 16'd2000;

    // Register indexes (word address bit 2 selects)
    localparam logic REG_DEBOUNCE    = 1'b0;
    localparam logic REG_START_DELAY = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_FAIL  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_INIT  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } t_action;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] start_delay_ticks;
    } t_cfg;

    // One result item
    typedef struct packed {
        t_action           action;
        logic              debounced_out;
        logic [HOLD_W-1:0] hold_ticks;
        logic              failed_out;
    } t_result;

endpackage

// ===== design/sdhs_in_if.sv =====
// ----------------------------------------------------------------------------
// sdhs_in_if
// Input request channel: a tick or a command with the raw switch level.
// ----------------------------------------------------------------------------
interface sdhs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       raw_level;

    modport source (output valid, output opcode, output raw_level, input ready);
    modport sink   (input valid, input opcode, input raw_level, output ready);
endinterface

// ===== design/sdhs_out_if.sv =====
// ----------------------------------------------------------------------------
// sdhs_out_if
// Result request channel: action and status after each input request.
// ----------------------------------------------------------------------------
interface sdhs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic        debounced_out;
    logic [15:0] hold_ticks;
    logic        failed_out;

    modport source (output valid, output action, output debounced_out,
                    output hold_ticks, output failed_out, input ready);
    modport sink   (input valid, input action, input debounced_out,
                    input hold_ticks, input failed_out, output ready);
endinterface

// ===== design/sdhs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sdhs_cfg_regs
// APB configuration registers: debounce threshold and start delay.
// ----------------------------------------------------------------------------
module sdhs_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sdhs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sdhs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sdhs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output sdhs_pkg::t_cfg                     o_cfg
);

    logic [sdhs_pkg::CFG_W-1:0] r_debounce_ticks;
    logic [sdhs_pkg::CFG_W-1:0] r_start_delay_ticks;
    logic                       wr_en;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks    <= sdhs_pkg::DEBOUNCE_RESET;
            r_start_delay_ticks <= sdhs_pkg::START_DELAY_RESET;
        end else if (wr_en) begin
            if (reg_sel == sdhs_pkg::REG_DEBOUNCE) begin
                r_debounce_ticks <= pwdata[sdhs_pkg::CFG_W-1:0];
            end else begin
                r_start_delay_ticks <= pwdata[sdhs_pkg::CFG_W-1:0];
            end
        end
    end

    // read mux
    always_comb begin
        if (reg_sel == sdhs_pkg::REG_DEBOUNCE) begin
            prdata = sdhs_pkg::APB_DATA_W'(r_debounce_ticks);
        end else begin
            prdata = sdhs_pkg::APB_DATA_W'(r_start_delay_ticks);
        end
    end

    assign o_cfg.debounce_ticks    = r_debounce_ticks;
    assign o_cfg.start_delay_ticks = r_start_delay_ticks;

endmodule

// ===== design/sdhs_state_update.sv =====
// ----------------------------------------------------------------------------
// sdhs_state_update
// Debounce and hold state, updated once per request on i_advance.
// ----------------------------------------------------------------------------
module sdhs_state_update #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [1:0]        i_opcode,
    input  logic              i_raw_level,
    input  sdhs_pkg::t_cfg    i_cfg,
    output sdhs_pkg::t_result o_result
);

    // compare width covers both counters and 16-bit thresholds
    localparam int unsigned CMP_W =
        (COUNT_WIDTH > sdhs_pkg::CFG_W) ? COUNT_WIDTH : sdhs_pkg::CFG_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [CMP_W-1:0]       HOLD_MAX  = CMP_W'({sdhs_pkg::HOLD_W{1'b1}});

    logic                   r_initialized,   n_initialized;
    logic                   r_debounced,     n_debounced;
    logic                   r_prev_raw,      n_prev_raw;
    logic [COUNT_WIDTH-1:0] r_stable_count,  n_stable_count;
    logic [COUNT_WIDTH-1:0] r_hold_count,    n_hold_count;
    logic                   r_hold_valid,    n_hold_valid;
    logic                   r_attempted,     n_attempted;
    logic                   r_failed,        n_failed;
    sdhs_pkg::t_action      n_action;
    logic [CMP_W-1:0]       hold_ext;

    // next state for one request
    always_comb begin
        n_initialized  = r_initialized;
        n_debounced    = r_debounced;
        n_prev_raw     = r_prev_raw;
        n_stable_count = r_stable_count;
        n_hold_count   = r_hold_count;
        n_hold_valid   = r_hold_valid;
        n_attempted    = r_attempted;
        n_failed       = r_failed;
        n_action       = sdhs_pkg::ACT_NONE;

        unique case (sdhs_pkg::t_opcode'(i_opcode))
            sdhs_pkg::OP_TICK: begin
                if (r_initialized) begin
                    if (r_hold_valid && r_hold_count != COUNT_MAX) begin
                        n_hold_count = r_hold_count + COUNT_WIDTH'(1);
                    end
                    if (i_raw_level != r_prev_raw) begin
                        n_stable_count = '0;
                    end else if (r_stable_count != COUNT_MAX) begin
                        n_stable_count = r_stable_count + COUNT_WIDTH'(1);
                    end
                    // level accepted once stable past the threshold
                    if (CMP_W'(n_stable_count) > CMP_W'(i_cfg.debounce_ticks)) begin
                        if (i_raw_level != r_debounced) begin
                            n_debounced  = i_raw_level;
                            n_hold_valid = i_raw_level;
                            n_hold_count = '0;
                            n_attempted  = 1'b0;
                            n_failed     = 1'b0;
                            if (!i_raw_level) begin
                                n_action = sdhs_pkg::ACT_STOP;
                            end
                        end
                        // one start per high or clear; delay only if hold valid
                        if (i_raw_level && n_debounced && !n_attempted && !n_failed &&
                            (!n_hold_valid ||
                             CMP_W'(n_hold_count) >= CMP_W'(i_cfg.start_delay_ticks))) begin
                            n_attempted = 1'b1;
                            n_action    = sdhs_pkg::ACT_START;
                        end
                    end
                    n_prev_raw = i_raw_level;
                end
            end
            sdhs_pkg::OP_FAIL: begin
                n_failed = 1'b1;
            end
            sdhs_pkg::OP_CLEAR: begin
                n_hold_valid = 1'b0;
                n_hold_count = '0;
                n_attempted  = 1'b0;
                n_failed     = 1'b0;
            end
            sdhs_pkg::OP_INIT: begin
                n_debounced    = i_raw_level;
                n_prev_raw     = i_raw_level;
                n_stable_count = '0;
                n_attempted    = 1'b0;
                n_failed       = 1'b0;
                n_initialized  = 1'b1;
            end
            default: begin
                n_action = sdhs_pkg::ACT_NONE;
            end
        endcase
    end

    // result fields after the step, hold shown saturated to 16 bits
    always_comb begin
        hold_ext               = n_hold_valid ? CMP_W'(n_hold_count) : '0;
        o_result.action        = n_action;
        o_result.debounced_out = n_debounced;
        o_result.failed_out    = n_failed;
        if (hold_ext > HOLD_MAX) begin
            o_result.hold_ticks = '1;
        end else begin
            o_result.hold_ticks = hold_ext[sdhs_pkg::HOLD_W-1:0];
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initialized  <= 1'b0;
            r_debounced    <= 1'b1;
            r_prev_raw     <= 1'b1;
            r_stable_count <= '0;
            r_hold_count   <= '0;
            r_hold_valid   <= 1'b0;
            r_attempted    <= 1'b0;
            r_failed       <= 1'b0;
        end else if (i_advance) begin
            r_initialized  <= n_initialized;
            r_debounced    <= n_debounced;
            r_prev_raw     <= n_prev_raw;
            r_stable_count <= n_stable_count;
            r_hold_count   <= n_hold_count;
            r_hold_valid   <= n_hold_valid;
            r_attempted    <= n_attempted;
            r_failed       <= n_failed;
        end
    end

endmodule

// ===== design/switch_debounce_hold_start_core.sv =====
// ----------------------------------------------------------------------------
// switch_debounce_hold_start_core
// Debounced switch with a delayed start request and a stop on release.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one request per millisecond tick or command (opcode,
//   raw_level). o_out returns exactly one result per request: action,
//   debounced level, hold ticks and the failed flag after that request.
//   The APB port holds debounce_ticks (0x0) and start_delay_ticks (0x4);
//   write them only while the block is idle.
// Pipeline: a request accepted on i_in passes the input register and then
//   the result register before its result shows on o_out (two register stages).
// Throughput: one request per cycle while o_out is not held; the state update
//   is a single pass of compares and counter increments between the two registers.
// Reset (synchronous, active low): channels empty, registers at 100 and
//   2000, switch uninitialized, ticks give no action until opcode 3.
// Stall: while o_out is held, the input register still takes one request;
//   i_in.ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module switch_debounce_hold_start_core #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sdhs_in_if.sink                            i_in,
    sdhs_out_if.source                         o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sdhs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sdhs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sdhs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    sdhs_pkg::t_cfg    cfg;
    sdhs_pkg::t_result n_result;
    sdhs_pkg::t_result r_result;
    logic              r_in_valid;
    logic [1:0]        r_in_opcode;
    logic              r_in_raw;
    logic              r_out_valid;
    logic              advance;

    // configuration registers
    sdhs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input stage moves to the result stage when that one is free
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_opcode <= i_in.opcode;
            r_in_raw    <= i_in.raw_level;
        end
    end

    // state update
    sdhs_state_update #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_opcode    (r_in_opcode),
        .i_raw_level (r_in_raw),
        .i_cfg       (cfg),
        .o_result    (n_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.action        = r_result.action;
    assign o_out.debounced_out = r_result.debounced_out;
    assign o_out.hold_ticks    = r_result.hold_ticks;
    assign o_out.failed_out    = r_result.failed_out;

`ifndef SYNTHESIS
    // a start needs a high position with no failed attempt
    a_start_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.action == sdhs_pkg::ACT_START
            |-> o_out.debounced_out && !o_out.failed_out)
        else $error("start request without high, unfailed position");

    // a stop leaves the switch low with the hold state cleared
    a_stop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.action == sdhs_pkg::ACT_STOP
            |-> !o_out.debounced_out && o_out.hold_ticks == '0 && !o_out.failed_out)
        else $error("stop request with stale hold state");

    // input side stalls only when both stages are full and output is held
    a_ready_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_in_valid && r_out_valid && !o_out.ready)
        else $error("input stalled while a stage is free");

    // a request in the input stage leaves it the cycle the result is taken
    a_drain_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_out.valid && o_out.ready |-> advance)
        else $error("input stage did not advance on a freed result");
`endif

endmodule
